// ===== sv/hqcb_pkg.sv =====
// Package for the hold qualified character buffer.
// Shared constants, register codes and control structs; no dependencies.
package hqcb_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int CHAR_W        = 8;
   localparam int TIME_W        = 32;
   localparam int CFG_W         = 16;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;

   localparam logic [CFG_W-1:0]  HOLD_MS_RESET = 16'd4000;
   localparam logic [CFG_W-1:0]  IDLE_MS_RESET = 16'd3000;
   localparam logic [CHAR_W-1:0] CHAR_NONE     = 8'd0;

   // register index, taken from paddr[2]
   localparam logic REG_HOLD_MS = 1'b0;
   localparam logic REG_IDLE_MS = 1'b1;

   typedef struct packed {
      logic [CFG_W-1:0] hold_ms;
      logic [CFG_W-1:0] idle_ms;
   } cfg_type;

   typedef struct packed {
      logic              append;
      logic              shift;
      logic [CHAR_W-1:0] wr_char;
   } cell_ctl_type;

endpackage

// ===== sv/hold_qualified_char_buffer_top.sv =====
// Channel   Ports                                   Direction
// req       req_valid/req_stall, char_in, now_ms    in
// rsp       rsp_valid/rsp_stall, char_out, last      out
// csr       psel/penable/pwrite/paddr/pwdata/prdata  in/out
//
// Samples are accepted while req_stall is low; it is low except during a flush.
// A flush of n characters shifts the cell chain once per rsp transfer and
// keeps req_stall high until all n characters have been transferred.
// Reset empties the buffer and loads hold_ms 4000, idle_ms 3000.
// Depends on hqcb_pkg, hqcb_csr, hqcb_ctrl and hqcb_cell.
module hold_qualified_char_buffer_top
   import hqcb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAR_W-1:0]     req_char_in,
   input  logic [TIME_W-1:0]     req_now_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAR_W-1:0]     rsp_char_out,
   output logic                  rsp_last_of_flush,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   cfg_type           cfg;
   cell_ctl_type      cell_ctl;
   logic [CNT_W-1:0]  fill_count;
   logic [CHAR_W-1:0] chain [DEPTH+1];

   hqcb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hqcb_ctrl #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_in       (req_char_in),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_last_of_flush (rsp_last_of_flush),
      .cell_ctl          (cell_ctl),
      .fill_count        (fill_count)
   );

   // tail of the chain feeds zeros in on a shift
   assign chain[DEPTH] = CHAR_NONE;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      hqcb_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .fill_count (fill_count),
         .next_char  (chain[i+1]),
         .char_q     (chain[i])
      );
   end

   assign rsp_char_out = chain[0];

endmodule

// ===== sv/hqcb_csr.sv =====
// Configuration registers behind the APB-style port.
// Depends on hqcb_pkg.
module hqcb_csr
   import hqcb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_HOLD_MS: cfg_in.hold_ms = pwdata[CFG_W-1:0];
            REG_IDLE_MS: cfg_in.idle_ms = pwdata[CFG_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_ms <= HOLD_MS_RESET;
         cfg_ff.idle_ms <= IDLE_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_HOLD_MS: prdata = {{(CSR_DATA_W-CFG_W){1'b0}}, cfg_ff.hold_ms};
         REG_IDLE_MS: prdata = {{(CSR_DATA_W-CFG_W){1'b0}}, cfg_ff.idle_ms};
         default:     prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/hqcb_cell.sv =====
// One character cell of the buffer chain.
// Depends on hqcb_pkg; loads on append at its own index, shifts toward the head on flush.
module hqcb_cell
   import hqcb_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int CNT_W = 6
)(
   input  logic              clock,
   input  cell_ctl_type      ctl,
   input  logic [CNT_W-1:0]  fill_count,
   input  logic [CHAR_W-1:0] next_char,
   output logic [CHAR_W-1:0] char_q
);

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   logic [CHAR_W-1:0] char_ff, char_in;

   always_comb begin
      char_in = char_ff;
      if (ctl.shift) begin
         char_in = next_char;
      end else if (ctl.append && fill_count == MY_IDX) begin
         char_in = ctl.wr_char;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

   assign char_q = char_ff;

endmodule

// ===== sv/hqcb_ctrl.sv =====
// Hold and idle timers, fill count and flush sequencing.
// Depends on hqcb_pkg; drives the cell chain through cell_ctl_type.
module hqcb_ctrl
   import hqcb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int CNT_W = $clog2(DEPTH + 1)
)(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CHAR_W-1:0] req_char_in,
   input  logic [TIME_W-1:0] req_now_ms,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_last_of_flush,
   output cell_ctl_type      cell_ctl,
   output logic [CNT_W-1:0]  fill_count
);

   localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              flush_ff, flush_in;
   logic              stored_ff, stored_in;
   logic              hold_valid_ff, hold_valid_in;
   logic              idle_valid_ff, idle_valid_in;
   logic [TIME_W-1:0] hold_start_ff, hold_start_in;
   logic [TIME_W-1:0] idle_start_ff, idle_start_in;

   logic              accept, out_xfer, is_none, append, start_flush;
   logic [TIME_W-1:0] hold_base, idle_base, hold_diff, idle_diff;

   assign accept   = req_valid & ~flush_ff;
   assign out_xfer = flush_ff & ~rsp_stall;
   assign is_none  = (req_char_in == CHAR_NONE);

   assign hold_base = hold_valid_ff ? hold_start_ff : req_now_ms;
   assign idle_base = idle_valid_ff ? idle_start_ff : req_now_ms;
   assign hold_diff = req_now_ms - hold_base;
   assign idle_diff = req_now_ms - idle_base;

   assign append = accept & ~is_none & ~stored_ff & (count_ff < CNT_DEPTH) &
                   (hold_diff >= {{(TIME_W-CFG_W){1'b0}}, cfg.hold_ms});
   assign start_flush = accept & is_none & (count_ff != '0) &
                        (idle_diff >= {{(TIME_W-CFG_W){1'b0}}, cfg.idle_ms});

   always_comb begin
      count_in      = count_ff;
      flush_in      = flush_ff;
      stored_in     = stored_ff;
      hold_valid_in = hold_valid_ff;
      idle_valid_in = idle_valid_ff;
      hold_start_in = hold_start_ff;
      idle_start_in = idle_start_ff;

      if (accept) begin
         if (is_none) begin
            hold_valid_in = 1'b0;
            stored_in     = 1'b0;
            if (count_ff != '0 && !idle_valid_ff) begin
               idle_start_in = req_now_ms;
               idle_valid_in = 1'b1;
            end
         end else if (!hold_valid_ff) begin
            hold_start_in = req_now_ms;
            hold_valid_in = 1'b1;
         end
         if (append) begin
            count_in      = count_ff + CNT_ONE;
            stored_in     = 1'b1;
            idle_valid_in = 1'b0;
         end
         // hold the input side until the whole run has drained
         if (start_flush) begin
            flush_in      = 1'b1;
            stored_in     = 1'b0;
            hold_valid_in = 1'b0;
            idle_valid_in = 1'b0;
         end
      end

      if (out_xfer) begin
         count_in = count_ff - CNT_ONE;
         if (count_ff == CNT_ONE) begin
            flush_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         flush_ff      <= 1'b0;
         stored_ff     <= 1'b0;
         hold_valid_ff <= 1'b0;
         idle_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         flush_ff      <= flush_in;
         stored_ff     <= stored_in;
         hold_valid_ff <= hold_valid_in;
         idle_valid_ff <= idle_valid_in;
      end
      hold_start_ff <= hold_start_in;
      idle_start_ff <= idle_start_in;
   end

   assign req_stall         = flush_ff;
   assign rsp_valid         = flush_ff;
   assign rsp_last_of_flush = (count_ff == CNT_ONE);

   assign cell_ctl.append  = append;
   assign cell_ctl.shift   = out_xfer;
   assign cell_ctl.wr_char = req_char_in;
   assign fill_count       = count_ff;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for hold_qualified_char_buffer_top: directed holds,
// a full-buffer fill and randomized key gestures under varying idle/stall pacing.
// Depends on hqcb_pkg and the RTL of the block; expected flush output is predicted here.
module tb_top;
   import hqcb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUF_DEPTH   = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } flush_char_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CHAR_W-1:0]     req_char_in = '0;
   logic [TIME_W-1:0]     req_now_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CHAR_W-1:0]     rsp_char_out;
   logic                  rsp_last_of_flush;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   hold_qualified_char_buffer_top #(.DEPTH(BUF_DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_in       (req_char_in),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_char_out      (rsp_char_out),
      .rsp_last_of_flush (rsp_last_of_flush),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // predicted state of the block
   logic [CHAR_W-1:0] held_chars[$];
   logic              char_taken;
   logic              hold_running;
   logic [TIME_W-1:0] hold_since;
   logic              idle_running;
   logic [TIME_W-1:0] idle_since;
   logic [CFG_W-1:0]  cfg_hold_ms;
   logic [CFG_W-1:0]  cfg_idle_ms;

   flush_char_type    due_chars[$];
   int                errors = 0;
   int                samples_sent = 0;
   int                chars_seen = 0;
   int                cycles = 0;
   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;
   logic [TIME_W-1:0] wall_ms;

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   function automatic void clear_buffer();
      held_chars.delete();
      char_taken   = 1'b0;
      hold_running = 1'b0;
      hold_since   = '0;
      idle_running = 1'b0;
      idle_since   = '0;
   endfunction

   function automatic void track_sample(input logic [CHAR_W-1:0] c, input logic [TIME_W-1:0] t);
      logic [TIME_W-1:0] held_for;
      logic [TIME_W-1:0] idle_for;
      if (c == CHAR_NONE) begin
         hold_running = 1'b0;
         char_taken   = 1'b0;
      end else if (!hold_running) begin
         hold_since   = t;
         hold_running = 1'b1;
      end
      held_for = t - hold_since;
      // a qualified hold on a full buffer is dropped and stays eligible
      if (!char_taken && c != CHAR_NONE && held_for >= TIME_W'(cfg_hold_ms)) begin
         if (held_chars.size() < BUF_DEPTH) begin
            held_chars.push_back(c);
            char_taken   = 1'b1;
            idle_running = 1'b0;
         end
      end
      if (c == CHAR_NONE && held_chars.size() > 0 && !idle_running) begin
         idle_since   = t;
         idle_running = 1'b1;
      end
      idle_for = t - idle_since;
      if (c == CHAR_NONE && held_chars.size() > 0 && idle_for >= TIME_W'(cfg_idle_ms)) begin
         foreach (held_chars[i])
            due_chars.push_back('{ch: held_chars[i], last: (i == held_chars.size() - 1)});
         clear_buffer();
      end
   endfunction

   always @(posedge clock) begin : monitor_blk
      flush_char_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            track_sample(req_char_in, req_now_ms);
         if (rsp_valid && !rsp_stall) begin
            chars_seen++;
            if (due_chars.size() == 0) begin
               errors++;
               $display("%0t: unexpected transfer, expected none, got char %h last %b",
                        $time, rsp_char_out, rsp_last_of_flush);
            end else begin
               want = due_chars.pop_front();
               if (rsp_char_out !== want.ch) begin
                  errors++;
                  $display("%0t: char_out expected %h got %h", $time, want.ch, rsp_char_out);
               end
               if (rsp_last_of_flush !== want.last) begin
                  errors++;
                  $display("%0t: last_of_flush expected %b got %b (char %h)",
                           $time, want.last, rsp_last_of_flush, want.ch);
               end
            end
         end
      end
   end

   task automatic send_sample(input logic [CHAR_W-1:0] c, input logic [TIME_W-1:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      req_now_ms  <= t;
      do @(posedge clock); while (req_stall);
      samples_sent++;
   endtask

   // hold off the sender until the whole flush has come out
   task automatic drain(input int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (due_chars.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic sel, input logic [CFG_W-1:0] value);
      logic [CSR_DATA_W-1:0] word;
      word = {16'($urandom), value};
      drain(4);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (sel == REG_HOLD_MS)
         cfg_hold_ms = word[CFG_W-1:0];
      else
         cfg_idle_ms = word[CFG_W-1:0];
   endtask

   function automatic logic [CFG_W-1:0] pick_ms();
      case ($urandom_range(4))
         0:       return '0;
         1:       return '1;
         2:       return CFG_W'($urandom_range(20, 1));
         default: return CFG_W'($urandom_range(65535));
      endcase
   endfunction

   // time step that lands just below, on or past a threshold
   function automatic logic [TIME_W-1:0] near(input logic [CFG_W-1:0] ms);
      case ($urandom_range(3))
         0:       return TIME_W'(ms) - 1;
         1:       return TIME_W'(ms);
         2:       return TIME_W'(ms) + 1;
         default: return $urandom_range(TIME_W'(ms));
      endcase
   endfunction

   // reset values, timestamp zero, exact hold and idle boundaries
   task automatic test_default_hold();
      send_sample(8'h41, 32'd0);
      send_sample(8'h41, 32'd3999);
      send_sample(8'h41, 32'd4000);
      send_sample(8'h41, 32'd9000);
      send_sample(CHAR_NONE, 32'd9001);
      send_sample(CHAR_NONE, 32'd12000);
      send_sample(CHAR_NONE, 32'd12001);
   endtask

   // zero hold stores on first sample, zero idle flushes on first release
   task automatic test_zero_settings();
      logic [TIME_W-1:0] t;
      t = $urandom;
      write_reg(REG_HOLD_MS, '0);
      write_reg(REG_IDLE_MS, '0);
      send_sample(8'hFF, t);
      send_sample(8'h80, t + 1);
      send_sample(CHAR_NONE, t + 2);
      send_sample(8'h01, t + 3);
      send_sample(CHAR_NONE, t + 3);
      send_sample(CHAR_NONE, t + 4);
   endtask

   // largest settings across the timestamp wrap; a press without a store
   // must not restart the running idle period
   task automatic test_max_settings();
      logic [TIME_W-1:0] t;
      logic [TIME_W-1:0] idle_t;
      t      = 32'hFFFF_8000;
      idle_t = t + 70000;
      write_reg(REG_HOLD_MS, '1);
      write_reg(REG_IDLE_MS, '1);
      send_sample(8'h43, t);
      send_sample(8'h43, t + 65534);
      send_sample(8'h43, t + 65535);
      send_sample(CHAR_NONE, idle_t);
      send_sample(8'h44, idle_t + 10);
      send_sample(CHAR_NONE, idle_t + 65534);
      send_sample(CHAR_NONE, idle_t + 65535);
   endtask

   // fill past capacity with short releases, then let the idle time expire
   task automatic test_full_buffer();
      write_reg(REG_HOLD_MS, '0);
      write_reg(REG_IDLE_MS, 16'd60000);
      wall_ms = $urandom;
      repeat (BUF_DEPTH + 8) begin
         send_sample(CHAR_W'($urandom_range(255, 1)), wall_ms);
         wall_ms += $urandom_range(100);
         send_sample(CHAR_NONE, wall_ms);
         wall_ms += $urandom_range(100);
      end
      wall_ms += 60000;
      send_sample(CHAR_NONE, wall_ms);
   endtask

   task automatic random_gesture();
      int                kind;
      logic [CHAR_W-1:0] ch;
      kind = $urandom_range(99);
      ch   = CHAR_W'($urandom_range(255, 1));
      if (kind < 80) begin
         send_sample(ch, wall_ms);
         repeat ($urandom_range(3)) begin
            wall_ms += near(cfg_hold_ms);
            send_sample(ch, wall_ms);
         end
         // switch keys without a release now and then
         if (kind >= 70) begin
            wall_ms += near(cfg_hold_ms);
            send_sample(CHAR_W'($urandom_range(255, 1)), wall_ms);
         end
         repeat ($urandom_range(3, 1)) begin
            wall_ms += near(cfg_idle_ms);
            send_sample(CHAR_NONE, wall_ms);
         end
      end else if (kind < 95) begin
         wall_ms += $urandom;
         send_sample($urandom_range(1) ? CHAR_NONE : ch, wall_ms);
      end else begin
         send_sample(ch, wall_ms);
         wall_ms += $urandom_range(2);
         send_sample(CHAR_NONE, wall_ms);
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
      int first_sample;
      int first_char;
      write_reg(REG_HOLD_MS, pick_ms());
      write_reg(REG_IDLE_MS, pick_ms());
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      first_sample  = samples_sent;
      first_char    = chars_seen;
      while (samples_sent - first_sample < n / 2)
         random_gesture();
      drain(0);
      while (samples_sent - first_sample < n
             || (chars_seen - first_char < 12 && samples_sent - first_sample < n + 8))
         random_gesture();
   endtask

   task automatic test_random();
      wall_ms = $urandom;
      run_phase(0, 0, 36);
      run_phase(75, 0, 36);
      run_phase(0, 75, 36);
      run_phase(14, 14, 36);
   endtask

   initial begin
      clear_buffer();
      cfg_hold_ms = HOLD_MS_RESET;
      cfg_idle_ms = IDLE_MS_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_hold();
      test_zero_settings();
      test_max_settings();
      test_full_buffer();
      test_random();
      drain(20);
      foreach (due_chars[i]) begin
         errors++;
         $display("%0t: missing char, expected %h last %b, got nothing",
                  $time, due_chars[i].ch, due_chars[i].last);
      end
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
